// ===== hdl/elhp_pkg.sv =====
// shared types, constants and helper functions of the event log header parser
package elhp_pkg;

   localparam int ELHP_MAX_RESULTS = 4;
   localparam int ELHP_FIFO_DEPTH  = 8;
   localparam int ELHP_HDR_FIELDS  = 7;

   localparam logic [7:0] CH_PIPE      = 8'h7C;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;

   localparam logic [7:0] CEF_MAGIC [4] = '{8'h43, 8'h45, 8'h46, 8'h3A};

   localparam logic [2:0] PREFIX_LEN = 3'd4;
   localparam logic [31:0] LIMIT_NEG = 32'h8000_0000;
   localparam logic [31:0] LIMIT_POS = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_STATUS    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_EMPTY       = 3'd1,
      ST_BAD_PREFIX  = 3'd2,
      ST_FEW_FIELDS  = 3'd3,
      ST_EMPTY_FIELD = 3'd4,
      ST_BAD_VERSION = 3'd5,
      ST_BAD_SEV     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_BLANK  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] byte_value;
      logic       last;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  field_index;
      logic [7:0]  data_byte;
      status_type  status;
      logic [31:0] version;
      logic [31:0] severity;
      logic        end_of_run;
   } result_type;

   typedef struct packed {
      logic [2:0]                        count;
      result_type [ELHP_MAX_RESULTS-1:0] items;
   } push_type;

   function automatic result_type make_result(input kind_type kind, input logic [2:0] fi,
                                              input logic [7:0] db, input status_type st,
                                              input logic [31:0] ver,
                                              input logic [31:0] sev);
      result_type r;
      r.kind        = kind;
      r.field_index = fi;
      r.data_byte   = db;
      r.status      = st;
      r.version     = ver;
      r.severity    = sev;
      r.end_of_run  = (kind == KIND_STATUS);
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   // returns {known, plain byte}
   function automatic logic [8:0] unescape(input logic [7:0] b);
      logic [8:0] r;
      unique case (b)
         CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
         CH_PIPE:      r = {1'b1, CH_PIPE};
         CH_EQUAL:     r = {1'b1, CH_EQUAL};
         CH_LOWER_N:   r = {1'b1, CH_LF};
         CH_LOWER_R:   r = {1'b1, CH_CR};
         CH_LOWER_T:   r = {1'b1, CH_TAB};
         default:      r = {1'b0, b};
      endcase
      return r;
   endfunction

   function automatic logic number_ok(input phase_type ph, input logic neg,
                                      input logic [31:0] mag, input logic ovf);
      logic in_range;
      in_range = neg ? (mag <= LIMIT_NEG) : (mag <= LIMIT_POS);
      return ((ph == PH_DIGITS) || (ph == PH_DONE)) && !ovf && in_range;
   endfunction

   function automatic logic [31:0] number_value(input logic neg, input logic [31:0] mag);
      return neg ? (32'd0 - mag) : mag;
   endfunction

endpackage

// ===== hdl/elhp_parse_core.sv =====
// per-byte parse step: line state registers and up to four results per item
module elhp_parse_core
   import elhp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  item_type item,
   output push_type push
);

   logic [2:0]  pos_ff, pos_in;
   logic        good_ff, good_in;
   logic        prev_bs_ff, prev_bs_in;
   logic        esc_ff, esc_in;
   logic [2:0]  fnum_ff, fnum_in;
   logic [6:0]  flags_ff, flags_in;
   phase_type   phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] vval_ff, vval_in;
   logic        vbad_ff, vbad_in;

   always_comb begin
      logic [7:0]  b;
      logic [2:0]  fn;
      logic [2:0]  n;
      logic [2:0]  fi;
      logic [3:0]  d;
      logic        dig;
      logic        found;
      logic [8:0]  unesc;
      logic [35:0] m;
      status_type  st;
      logic [31:0] ver;
      logic [31:0] sev;
      result_type [ELHP_MAX_RESULTS-1:0] res;

      pos_in     = pos_ff;
      good_in    = good_ff;
      prev_bs_in = prev_bs_ff;
      esc_in     = esc_ff;
      fnum_in    = fnum_ff;
      flags_in   = flags_ff;
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      ovf_in     = ovf_ff;
      vval_in    = vval_ff;
      vbad_in    = vbad_ff;
      res        = '0;
      n          = 3'd0;
      b          = item.byte_value;
      fn         = fnum_ff;
      fi         = 3'd0;
      found      = 1'b0;
      st         = ST_OK;
      ver        = 32'd0;
      sev        = 32'd0;
      m          = 36'd0;
      dig        = (b >= CH_ZERO) && (b <= CH_NINE);
      d          = 4'(b - CH_ZERO);
      unesc      = unescape(b);

      if (enable && item.has_byte) begin
         if (pos_ff < PREFIX_LEN) begin
            if (b != CEF_MAGIC[pos_ff[1:0]]) begin
               good_in = 1'b0;
            end
            pos_in = pos_ff + 3'd1;
         end else if (good_ff) begin
            if ((fn < 3'd7) && (b == CH_PIPE) && !prev_bs_ff) begin
               res[n[1:0]] = make_result(KIND_FIELD_END, fn, 8'd0, ST_OK, 32'd0, 32'd0);
               n = n + 3'd1;
               if (fn == 3'd0) begin
                  vbad_in = !number_ok(phase_ff, neg_ff, mag_ff, ovf_ff);
                  vval_in = number_value(neg_ff, mag_ff);
               end
               fnum_in = fn + 3'd1;
               if (fnum_in == 3'd6) begin
                  phase_in = PH_BLANK;
                  neg_in   = 1'b0;
                  mag_in   = 32'd0;
                  ovf_in   = 1'b0;
               end
               prev_bs_in = 1'b0;
               esc_in     = 1'b0;
            end else begin
               if (fn < 3'd7) begin
                  flags_in[fn] = 1'b1;
               end
               if ((fn >= 3'd1) && (fn <= 3'd5)) begin
                  if (esc_ff) begin
                     esc_in = 1'b0;
                     if (unesc[8]) begin
                        res[n[1:0]] = make_result(KIND_DATA, fn, unesc[7:0], ST_OK,
                                                  32'd0, 32'd0);
                        n = n + 3'd1;
                     end else begin
                        res[n[1:0]] = make_result(KIND_DATA, fn, CH_BACKSLASH, ST_OK,
                                                  32'd0, 32'd0);
                        n = n + 3'd1;
                        res[n[1:0]] = make_result(KIND_DATA, fn, b, ST_OK, 32'd0, 32'd0);
                        n = n + 3'd1;
                     end
                  end else if (b == CH_BACKSLASH) begin
                     esc_in = 1'b1;
                  end else begin
                     res[n[1:0]] = make_result(KIND_DATA, fn, b, ST_OK, 32'd0, 32'd0);
                     n = n + 3'd1;
                  end
               end else begin
                  res[n[1:0]] = make_result(KIND_DATA, fn, b, ST_OK, 32'd0, 32'd0);
                  n = n + 3'd1;
                  // decimal conversion of version and severity
                  if ((fn == 3'd0) || (fn == 3'd6)) begin
                     unique case (phase_ff)
                        PH_BLANK: begin
                           if (is_blank(b)) begin
                              phase_in = PH_BLANK;
                           end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                              neg_in   = (b == CH_MINUS);
                              phase_in = PH_SIGN;
                           end else if (dig) begin
                              mag_in   = 32'(d);
                              phase_in = PH_DIGITS;
                           end else begin
                              ovf_in   = 1'b1;
                              phase_in = PH_DONE;
                           end
                        end
                        PH_SIGN: begin
                           if (dig) begin
                              mag_in   = 32'(d);
                              phase_in = PH_DIGITS;
                           end else begin
                              ovf_in   = 1'b1;
                              phase_in = PH_DONE;
                           end
                        end
                        PH_DIGITS: begin
                           if (!dig) begin
                              phase_in = PH_DONE;
                           end else if (!ovf_ff) begin
                              m = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) + 36'(d);
                              if (m > 36'(LIMIT_NEG)) begin
                                 ovf_in = 1'b1;
                              end else begin
                                 mag_in = m[31:0];
                              end
                           end
                        end
                        PH_DONE: begin
                           phase_in = PH_DONE;
                        end
                        default: begin
                           phase_in = PH_DONE;
                        end
                     endcase
                  end
               end
               prev_bs_in = (b == CH_BACKSLASH);
            end
         end
      end

      if (enable && item.last) begin
         fn = fnum_in;
         if (pos_in == 3'd0) begin
            st = ST_EMPTY;
         end else if ((pos_in < PREFIX_LEN) || !good_in) begin
            st = ST_BAD_PREFIX;
         end else begin
            if (esc_in && (fn >= 3'd1) && (fn <= 3'd5)) begin
               res[n[1:0]] = make_result(KIND_DATA, fn, CH_BACKSLASH, ST_OK, 32'd0, 32'd0);
               n = n + 3'd1;
            end
            res[n[1:0]] = make_result(KIND_FIELD_END, fn, 8'd0, ST_OK, 32'd0, 32'd0);
            n = n + 3'd1;
            if (fn < 3'd6) begin
               st = ST_FEW_FIELDS;
            end else begin
               for (int i = 0; i < ELHP_HDR_FIELDS; i++) begin
                  if (!found && !flags_in[i]) begin
                     found = 1'b1;
                     fi    = 3'(i);
                     st    = ST_EMPTY_FIELD;
                  end
               end
               if ((st == ST_OK) && vbad_in) begin
                  st = ST_BAD_VERSION;
               end
               if ((st == ST_OK) && !number_ok(phase_in, neg_in, mag_in, ovf_in)) begin
                  st = ST_BAD_SEV;
               end
               if (st == ST_OK) begin
                  ver = vval_in;
                  sev = number_value(neg_in, mag_in);
               end
            end
         end
         res[n[1:0]] = make_result(KIND_STATUS, fi, 8'd0, st, ver, sev);
         n = n + 3'd1;
         // back to the reset state for the next line
         pos_in     = 3'd0;
         good_in    = 1'b1;
         prev_bs_in = 1'b0;
         esc_in     = 1'b0;
         fnum_in    = 3'd0;
         flags_in   = 7'd0;
         phase_in   = PH_BLANK;
         neg_in     = 1'b0;
         mag_in     = 32'd0;
         ovf_in     = 1'b0;
         vval_in    = 32'd0;
         vbad_in    = 1'b0;
      end

      push.count = n;
      push.items = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 3'd0;
         good_ff    <= 1'b1;
         prev_bs_ff <= 1'b0;
         esc_ff     <= 1'b0;
         fnum_ff    <= 3'd0;
         flags_ff   <= 7'd0;
         phase_ff   <= PH_BLANK;
         neg_ff     <= 1'b0;
         mag_ff     <= 32'd0;
         ovf_ff     <= 1'b0;
         vval_ff    <= 32'd0;
         vbad_ff    <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         good_ff    <= good_in;
         prev_bs_ff <= prev_bs_in;
         esc_ff     <= esc_in;
         fnum_ff    <= fnum_in;
         flags_ff   <= flags_in;
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         mag_ff     <= mag_in;
         ovf_ff     <= ovf_in;
         vval_ff    <= vval_in;
         vbad_ff    <= vbad_in;
      end
   end

endmodule

// ===== hdl/elhp_result_fifo.sv =====
// result queue: up to four entries written per cycle, one read per cycle
module elhp_result_fifo
   import elhp_pkg::*;
#(
   parameter int FIFO_DEPTH = ELHP_FIFO_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  push_type                       push,
   input  logic                           pop,
   output logic                           head_valid,
   output result_type                     head,
   output logic                           room,
   output logic [$clog2(FIFO_DEPTH+1)-1:0] level
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   result_type       mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign room       = (count_ff <= CNT_W'(FIFO_DEPTH - ELHP_MAX_RESULTS));
   assign level      = count_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ELHP_MAX_RESULTS; i++) begin
         if (3'(i) < push.count) begin
            mem_ff[wr_ptr_ff + PTR_W'(i)] <= push.items[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/event_log_header_parser_top.sv =====
// top level of the event log header parser: input register, parse step, result queue
//
// usage
// - req channel: one byte of a CEF event line per transfer (req_has_byte, req_byte_value)
//   with req_last on the final byte; req_has_byte low with req_last closes an empty line
// - rsp channel: data bytes tagged with their header field, one field-end per field, and a
//   closing status transfer (rsp_end_of_run high) carrying version and severity
// - each input transfer yields zero to four result transfers
// - an accepted byte is held in the input register until the queue has room, is parsed
//   into the result queue, and its first result is shown from there
// - throughput: one input per cycle while the queue has room, one result per cycle
//   while rsp_ready is high; a line runs at one byte per cycle bar escapes and line ends
// - the result queue (FIFO_DEPTH entries, a power of two, at least four) sets the
//   slack; a new byte is parsed only while four free entries remain
// - receiver stall: results wait in the queue, the input register holds its byte and
//   req_ready drops once the register is full and the queue lacks room
// - reset: synchronous, clears the line state, the queue and the input register's valid
//   flag; the block is ready once reset is released
module event_log_header_parser_top
   import elhp_pkg::*;
#(
   parameter int FIFO_DEPTH = ELHP_FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_has_byte,
   input  logic [7:0]         req_byte_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_field_index,
   output logic [7:0]         rsp_data_byte,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_version,
   output logic signed [31:0] rsp_severity,
   output logic               rsp_end_of_run
);

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // input register
   logic             in_valid_ff, in_valid_in;
   item_type         item_ff, item_in;
   logic             req_xfer;
   logic             process;

   // parse step into queue
   push_type         push;
   result_type       head;
   logic             room;
   logic [CNT_W-1:0] level;

   assign req_xfer  = req_valid && req_ready;
   // the held byte is parsed as soon as the queue has room for its worst case
   assign process   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         item_in.has_byte   = req_has_byte;
         item_in.byte_value = req_byte_value;
         item_in.last       = req_last;
         in_valid_in        = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   elhp_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (process),
      .item   (item_ff),
      .push   (push)
   );

   elhp_result_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_ready),
      .head_valid (rsp_valid),
      .head       (head),
      .room       (room),
      .level      (level)
   );

   // result fields straight from the queue head
   assign rsp_kind        = head.kind;
   assign rsp_field_index = head.field_index;
   assign rsp_data_byte   = head.data_byte;
   assign rsp_status      = head.status;
   assign rsp_version     = $signed(head.version);
   assign rsp_severity    = $signed(head.severity);
   assign rsp_end_of_run  = head.end_of_run;

   // queue never holds more than its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= CNT_W'(FIFO_DEPTH))
      else $error("result queue over depth");

   // the closing marker rides only on a status transfer
   a_eor_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_run |-> rsp_kind == KIND_STATUS)
      else $error("end of run on non-status result");

   // data and field-end transfers carry no status or numbers
   a_non_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_STATUS |->
         rsp_status == ST_OK && rsp_version == 0 && rsp_severity == 0)
      else $error("payload leak into non-status result");

   // nothing is shown right after reset is released
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule
